// ----- rtl/core/triangle_tangent_basis_macros.svh -----
// assertion macros for the triangle tangent basis block
// used by rtl/core files that check their own control logic
`ifndef TRIANGLE_TANGENT_BASIS_MACROS_SVH
`define TRIANGLE_TANGENT_BASIS_MACROS_SVH

// same-cycle implication
`define TTB_ASSERT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TTB_ASSERT_NEXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/ttb_pkg.sv -----
// shared widths and transaction types for the triangle tangent basis block
// no dependencies; imported by ttb_div, triangle_tangent_basis, the checker and the testbench
`default_nettype none

package ttb_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int DW          = COORD_WIDTH + 1;
	localparam int PW          = 2 * DW;
	localparam int AW          = PW + 1;
	localparam int RW          = AW + 1;
	localparam int QW          = COORD_WIDTH - 1;
	localparam int NW          = AW + FRAC_BITS;
	localparam int CW          = $clog2(QW + 1);

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] pos_x;
		logic signed [COORD_WIDTH-1:0] pos_y;
		logic signed [COORD_WIDTH-1:0] pos_z;
		logic signed [COORD_WIDTH-1:0] tex_u;
		logic signed [COORD_WIDTH-1:0] tex_v;
	} vtx_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] tangent_x;
		logic signed [COORD_WIDTH-1:0] tangent_y;
		logic signed [COORD_WIDTH-1:0] tangent_z;
		logic signed [COORD_WIDTH-1:0] bitangent_x;
		logic signed [COORD_WIDTH-1:0] bitangent_y;
		logic signed [COORD_WIDTH-1:0] bitangent_z;
		logic [1:0]                    corner_index;
		logic                          degenerate;
		logic                          last_of_triangle;
	} res_t;

	typedef struct packed {
		logic          start;
		logic          neg;
		logic [AW-1:0] num;
		logic [AW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                   busy;
		logic                   done;
		logic [COORD_WIDTH-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/ttb_div.sv -----
// iterative restoring divider: (num * 2^FRAC_BITS) / den, saturated, one bit per cycle
// depends on ttb_pkg
`default_nettype none

module ttb_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ttb_pkg::div_req_t req,
	output ttb_pkg::div_rsp_t rsp
);
	import ttb_pkg::*;

	logic          busy_q;
	logic          done_q;
	logic          sat_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic [RW-1:0] rem_q;
	logic [AW-1:0] den_q;
	logic [QW-1:0] nlow_q;
	logic [QW-1:0] quo_q;

	logic [NW-1:0] n_full;
	logic [RW-1:0] n_hi;
	logic [RW-1:0] den_ext;
	logic [RW-1:0] trial;
	logic          ge;
	logic          ovf;
	logic [COORD_WIDTH-1:0] mag;

	assign n_full  = {req.num, {FRAC_BITS{1'b0}}};
	assign n_hi    = RW'(n_full[NW-1:QW]);
	assign ovf     = n_hi >= RW'(req.den);
	assign den_ext = RW'(den_q);
	assign trial   = {rem_q[RW-2:0], nlow_q[QW-1]};
	assign ge      = trial >= den_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (ovf) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CW'(QW);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q  <= req.den;
			neg_q  <= req.neg;
			sat_q  <= ovf;
			rem_q  <= n_hi;
			nlow_q <= n_full[QW-1:0];
		end else if (busy_q) begin
			rem_q  <= ge ? trial - den_ext : trial;
			nlow_q <= {nlow_q[QW-2:0], 1'b0};
			quo_q  <= {quo_q[QW-2:0], ge};
		end
	end

	assign mag = {1'b0, quo_q};

	always_comb begin
		rsp.busy = busy_q;
		rsp.done = done_q;
		if (sat_q) begin
			rsp.quot = neg_q ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
		end else begin
			rsp.quot = neg_q ? -mag : mag;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/triangle_tangent_basis.sv -----
// triangle tangent basis: per-triangle tangent and bitangent from position and uv
// depends on ttb_pkg, ttb_div and triangle_tangent_basis_macros.svh
//
// usage
//   vtx channel: one vertex per transaction (vtx_valid / vtx_stall, payload vtx).
//   res channel: one result per transaction (res_valid / res_stall, payload res).
//   vertices form a triangle list; the first two corners are held in registers.
//   the third corner starts the shared multiplier and the shared divider:
//     the determinant takes two products and an accumulate, and each of the six components
//     takes two products, an accumulate and 31 divider steps, with fewer divider steps
//     when components saturate; a zero determinant skips straight to output.
//   the three results (corners 0, 1, 2) then leave on consecutive cycles
//   unless res_stall holds them; the last carries last_of_triangle.
//   the divider and multiplier set the rate: one quotient bit per cycle.
//   vtx_stall stays high from the third corner until the last result is taken.
//   reset clears the corner count and the sequencer; held corners are not cleared.
`default_nettype none
`include "triangle_tangent_basis_macros.svh"

module triangle_tangent_basis (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vtx_valid,
	output logic          vtx_stall,
	input  ttb_pkg::vtx_t vtx,
	output logic          res_valid,
	input  logic          res_stall,
	output ttb_pkg::res_t res
);
	import ttb_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	localparam logic [2:0] TERM_DET = 3'd0;
	localparam logic [2:0] TERM_TX  = 3'd1;
	localparam logic [2:0] TERM_TY  = 3'd2;
	localparam logic [2:0] TERM_TZ  = 3'd3;
	localparam logic [2:0] TERM_BX  = 3'd4;
	localparam logic [2:0] TERM_BY  = 3'd5;
	localparam logic [2:0] TERM_BZ  = 3'd6;

	logic [2:0] state_q;
	logic [1:0] count_q;
	logic [2:0] term_q;
	logic       half_q;
	logic [1:0] corner_q;

	logic signed [COORD_WIDTH-1:0] hp_q [2][3];
	logic signed [COORD_WIDTH-1:0] ht_q [2][2];
	logic signed [DW-1:0]          dp1_q [3];
	logic signed [DW-1:0]          dp2_q [3];
	logic signed [DW-1:0]          du1_q, dv1_q, du2_q, dv2_q;
	logic signed [PW-1:0]          prod_s1;
	logic signed [AW-1:0]          acc_q;
	logic [AW-1:0]                 det_mag_q;
	logic                          det_neg_q;
	logic                          degen_q;
	logic [COORD_WIDTH-1:0]        res_q [6];

	logic signed [COORD_WIDTH-1:0] pos_in [3];
	logic                          vtx_acc;
	logic                          res_acc;
	logic [1:0]                    lane;
	logic                          is_tan;
	logic signed [DW-1:0]          op_a, op_b;
	logic signed [PW-1:0]          prod;
	logic signed [AW-1:0]          diff;
	logic                          diff_neg;
	logic [AW-1:0]                 diff_mag;
	logic [2:0]                    res_idx;
	div_req_t                      div_req;
	div_rsp_t                      div_rsp;

	assign pos_in[0] = vtx.pos_x;
	assign pos_in[1] = vtx.pos_y;
	assign pos_in[2] = vtx.pos_z;

	assign vtx_stall = state_q != ST_IDLE;
	assign vtx_acc   = vtx_valid && !vtx_stall;
	assign res_valid = state_q == ST_OUT;
	assign res_acc   = res_valid && !res_stall;

	always_comb begin
		case (term_q)
			TERM_TX, TERM_BX: lane = 2'd0;
			TERM_TY, TERM_BY: lane = 2'd1;
			TERM_TZ, TERM_BZ: lane = 2'd2;
			default:          lane = 2'd0;
		endcase
	end

	assign is_tan = (term_q == TERM_TX) || (term_q == TERM_TY) || (term_q == TERM_TZ);

	// operand select for the shared multiplier
	always_comb begin
		if (term_q == TERM_DET) begin
			op_a = half_q ? dv1_q : du1_q;
			op_b = half_q ? du2_q : dv2_q;
		end else if (is_tan) begin
			op_a = half_q ? dp2_q[lane] : dp1_q[lane];
			op_b = half_q ? dv1_q : dv2_q;
		end else begin
			op_a = half_q ? dp1_q[lane] : dp2_q[lane];
			op_b = half_q ? du2_q : du1_q;
		end
	end

	assign prod     = op_a * op_b;
	assign diff     = acc_q - AW'(prod_s1);
	assign diff_neg = diff[AW-1];
	assign diff_mag = diff_neg ? -diff : diff;
	assign res_idx  = term_q - 3'd1;

	always_comb begin
		div_req.start = (state_q == ST_ACC) && half_q && (term_q != TERM_DET);
		div_req.neg   = diff_neg ^ det_neg_q;
		div_req.num   = diff_mag;
		div_req.den   = det_mag_q;
	end

	ttb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= 2'd0;
			term_q   <= TERM_DET;
			half_q   <= 1'b0;
			corner_q <= 2'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (vtx_acc) begin
						if (count_q == 2'd2) begin
							count_q <= 2'd0;
							term_q  <= TERM_DET;
							half_q  <= 1'b0;
							state_q <= ST_MUL;
						end else begin
							count_q <= count_q + 2'd1;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (!half_q) begin
						half_q  <= 1'b1;
						state_q <= ST_MUL;
					end else if (term_q == TERM_DET) begin
						half_q <= 1'b0;
						if (diff == '0) begin
							corner_q <= 2'd0;
							state_q  <= ST_OUT;
						end else begin
							term_q  <= TERM_TX;
							state_q <= ST_MUL;
						end
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						half_q <= 1'b0;
						if (term_q == TERM_BZ) begin
							corner_q <= 2'd0;
							state_q  <= ST_OUT;
						end else begin
							term_q  <= term_q + 3'd1;
							state_q <= ST_MUL;
						end
					end
				end
				ST_OUT: begin
					if (res_acc) begin
						corner_q <= corner_q + 2'd1;
						if (corner_q == 2'd2) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (vtx_acc) begin
			if (count_q == 2'd2) begin
				for (int i = 0; i < 3; i++) begin
					dp1_q[i] <= DW'(hp_q[1][i]) - DW'(hp_q[0][i]);
					dp2_q[i] <= DW'(pos_in[i]) - DW'(hp_q[0][i]);
				end
				du1_q <= DW'(ht_q[1][0]) - DW'(ht_q[0][0]);
				dv1_q <= DW'(ht_q[1][1]) - DW'(ht_q[0][1]);
				du2_q <= DW'(vtx.tex_u) - DW'(ht_q[0][0]);
				dv2_q <= DW'(vtx.tex_v) - DW'(ht_q[0][1]);
				degen_q <= 1'b0;
			end else begin
				for (int i = 0; i < 3; i++) begin
					hp_q[count_q[0]][i] <= pos_in[i];
				end
				ht_q[count_q[0]][0] <= vtx.tex_u;
				ht_q[count_q[0]][1] <= vtx.tex_v;
			end
		end
		if (state_q == ST_MUL) begin
			prod_s1 <= prod;
		end
		if (state_q == ST_ACC) begin
			if (!half_q) begin
				acc_q <= AW'(prod_s1);
			end else if (term_q == TERM_DET) begin
				det_mag_q <= diff_mag;
				det_neg_q <= diff_neg;
				if (diff == '0) begin
					degen_q <= 1'b1;
					for (int i = 0; i < 6; i++) begin
						res_q[i] <= '0;
					end
				end
			end
		end
		if ((state_q == ST_DIV) && div_rsp.done) begin
			res_q[res_idx] <= div_rsp.quot;
		end
	end

	always_comb begin
		res.tangent_x        = res_q[0];
		res.tangent_y        = res_q[1];
		res.tangent_z        = res_q[2];
		res.bitangent_x      = res_q[3];
		res.bitangent_y      = res_q[4];
		res.bitangent_z      = res_q[5];
		res.corner_index     = corner_q;
		res.degenerate       = degen_q;
		res.last_of_triangle = corner_q == 2'd2;
	end

	`TTB_ASSERT_NEXT(a_third_corner_blocks, clk, arst_n, vtx_acc && (count_q == 2'd2), vtx_stall, "third corner did not start the sequencer")
	`TTB_ASSERT(a_degen_zero, clk, arst_n, res_valid && res.degenerate, (res.tangent_x == '0) && (res.bitangent_z == '0), "degenerate result carries nonzero vectors")
	`TTB_ASSERT(a_corner_range, clk, arst_n, res_valid, res.corner_index != 2'd3, "corner index out of range")
	`TTB_ASSERT(a_div_start_idle, clk, arst_n, div_req.start, !div_rsp.busy, "divider restarted while busy")
	`TTB_ASSERT(a_out_count_clear, clk, arst_n, res_valid, count_q == 2'd0, "corner count not cleared while results pending")

endmodule

`default_nettype wire

// ----- sim/triangle_tangent_basis_checker.sv -----
// transaction checker for triangle_tangent_basis: predicts tangent and bitangent per triangle
// and compares every result transaction with the oldest expectation
// depends on ttb_pkg for the vertex and result transaction types
`timescale 1ns / 1ps

module triangle_tangent_basis_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vtx_valid,
	input  logic          vtx_stall,
	input  ttb_pkg::vtx_t vtx,
	input  logic          res_valid,
	input  logic          res_stall,
	input  ttb_pkg::res_t res,
	output int            mismatches,
	output int            results_owed
);
	import ttb_pkg::*;

	localparam logic signed [127:0] QUOT_MAX = (128'sd1 <<< (COORD_WIDTH - 1)) - 128'sd1;
	localparam logic signed [127:0] QUOT_MIN = -(128'sd1 <<< (COORD_WIDTH - 1));

	logic signed [127:0] held_pos [2][3];
	logic signed [127:0] held_uv [2][2];
	logic [1:0]          corners_held;
	res_t                basis_q [$];

	function automatic logic signed [127:0] widen(logic [COORD_WIDTH-1:0] x);
		return {{(128 - COORD_WIDTH){x[COORD_WIDTH-1]}}, x};
	endfunction

	// exact quotient toward zero, then clamp to the coordinate range
	function automatic logic [COORD_WIDTH-1:0] scaled_ratio(logic signed [127:0] num,
			logic signed [127:0] det);
		logic signed [127:0] q;
		q = (num <<< FRAC_BITS) / det;
		if (q > QUOT_MAX)
			return QUOT_MAX[COORD_WIDTH-1:0];
		if (q < QUOT_MIN)
			return QUOT_MIN[COORD_WIDTH-1:0];
		return q[COORD_WIDTH-1:0];
	endfunction

	task automatic take_vertex(vtx_t v);
		logic signed [127:0] p [3];
		logic signed [127:0] e1 [3];
		logic signed [127:0] e2 [3];
		logic signed [127:0] u, w, du1, dv1, du2, dv2, det;
		logic [COORD_WIDTH-1:0] tv [3];
		logic [COORD_WIDTH-1:0] bv [3];
		res_t r;
		int i, k;
		p[0] = widen(v.pos_x);
		p[1] = widen(v.pos_y);
		p[2] = widen(v.pos_z);
		u = widen(v.tex_u);
		w = widen(v.tex_v);
		if (corners_held < 2'd2) begin
			for (i = 0; i < 3; i++)
				held_pos[corners_held[0]][i] = p[i];
			held_uv[corners_held[0]][0] = u;
			held_uv[corners_held[0]][1] = w;
			corners_held = corners_held + 2'd1;
			return;
		end
		corners_held = 2'd0;
		for (i = 0; i < 3; i++) begin
			e1[i] = held_pos[1][i] - held_pos[0][i];
			e2[i] = p[i] - held_pos[0][i];
		end
		du1 = held_uv[1][0] - held_uv[0][0];
		dv1 = held_uv[1][1] - held_uv[0][1];
		du2 = u - held_uv[0][0];
		dv2 = w - held_uv[0][1];
		det = du1 * dv2 - dv1 * du2;
		for (i = 0; i < 3; i++) begin
			if (det == 0) begin
				tv[i] = '0;
				bv[i] = '0;
			end else begin
				tv[i] = scaled_ratio(e1[i] * dv2 - e2[i] * dv1, det);
				bv[i] = scaled_ratio(e2[i] * du1 - e1[i] * du2, det);
			end
		end
		for (k = 0; k < 3; k++) begin
			r.tangent_x        = tv[0];
			r.tangent_y        = tv[1];
			r.tangent_z        = tv[2];
			r.bitangent_x      = bv[0];
			r.bitangent_y      = bv[1];
			r.bitangent_z      = bv[2];
			r.corner_index     = 2'(k);
			r.degenerate       = (det == 0);
			r.last_of_triangle = (k == 2);
			basis_q = {basis_q, r};
		end
	endtask

	task automatic report(string what, logic [COORD_WIDTH-1:0] got,
			logic [COORD_WIDTH-1:0] want);
		$display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic check_result(res_t got);
		res_t want;
		if (basis_q.size() == 0) begin
			report("unexpected transaction, tangent_x", got.tangent_x, '0);
			return;
		end
		want = basis_q.pop_front();
		if (got.tangent_x !== want.tangent_x)
			report("tangent_x", got.tangent_x, want.tangent_x);
		if (got.tangent_y !== want.tangent_y)
			report("tangent_y", got.tangent_y, want.tangent_y);
		if (got.tangent_z !== want.tangent_z)
			report("tangent_z", got.tangent_z, want.tangent_z);
		if (got.bitangent_x !== want.bitangent_x)
			report("bitangent_x", got.bitangent_x, want.bitangent_x);
		if (got.bitangent_y !== want.bitangent_y)
			report("bitangent_y", got.bitangent_y, want.bitangent_y);
		if (got.bitangent_z !== want.bitangent_z)
			report("bitangent_z", got.bitangent_z, want.bitangent_z);
		if (got.corner_index !== want.corner_index)
			report("corner_index", COORD_WIDTH'(got.corner_index),
				COORD_WIDTH'(want.corner_index));
		if (got.degenerate !== want.degenerate)
			report("degenerate", COORD_WIDTH'(got.degenerate),
				COORD_WIDTH'(want.degenerate));
		if (got.last_of_triangle !== want.last_of_triangle)
			report("last_of_triangle", COORD_WIDTH'(got.last_of_triangle),
				COORD_WIDTH'(want.last_of_triangle));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corners_held = 2'd0;
		end else begin
			if (vtx_valid && !vtx_stall)
				take_vertex(vtx);
			if (res_valid && !res_stall)
				check_result(res);
		end
		results_owed = basis_q.size();
	end

endmodule

// ----- sim/triangle_tangent_basis_test.sv -----
// testbench top for triangle_tangent_basis: clock, reset, vertex stimulus and result stalls
// depends on ttb_pkg, the block and triangle_tangent_basis_checker
`timescale 1ns / 1ps

module triangle_tangent_basis_test;

	import ttb_pkg::*;

	typedef enum int {
		SHAPE_PLAIN,
		SHAPE_WIDE,
		SHAPE_FLAT,
		SHAPE_STEEP,
		SHAPE_LOOSE
	} shape_e;

	localparam logic [31:0] ONE  = 32'h0001_0000;
	localparam logic [31:0] TOP  = 32'h7fff_ffff;
	localparam logic [31:0] BOT  = 32'h8000_0000;
	localparam int          NEAR = 64 << 16;

	logic clk;
	logic arst_n    = 1'b0;
	logic vtx_valid = 1'b0;
	vtx_t vtx       = '0;
	logic res_stall = 1'b0;
	logic vtx_stall;
	logic res_valid;
	res_t res;
	int   mismatches;
	int   results_owed;
	int   vertices_sent;

	triangle_tangent_basis dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.vtx       (vtx),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	triangle_tangent_basis_checker basis_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.vtx_valid    (vtx_valid),
		.vtx_stall    (vtx_stall),
		.vtx          (vtx),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res          (res),
		.mismatches   (mismatches),
		.results_owed (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("** triangle_tangent_basis: FAILED **");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [31:0] rand_coord(int span);
		if (span <= 0)
			return $urandom;
		return 32'($urandom_range(0, 2 * span)) - 32'(span);
	endfunction

	function automatic vtx_t corner(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] u, logic [31:0] v);
		vtx_t c;
		c.pos_x = x;
		c.pos_y = y;
		c.pos_z = z;
		c.tex_u = u;
		c.tex_v = v;
		return c;
	endfunction

	task automatic offer_vertex(vtx_t v, bit no_gap);
		int gap;
		vtx       <= v;
		vtx_valid <= 1'b1;
		do
			@(posedge clk);
		while (vtx_stall);
		vertices_sent++;
		gap = no_gap ? 0 : idle_length();
		if (gap > 0) begin
			vtx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_triangle(vtx_t a, vtx_t b, vtx_t c);
		offer_vertex(a, 1'b0);
		offer_vertex(b, 1'b0);
		offer_vertex(c, 1'b0);
	endtask

	task automatic drain_results();
		vtx_valid <= 1'b0;
		@(posedge clk);
		wait (results_owed == 0);
		@(posedge clk);
	endtask

	task automatic random_triangle(shape_e shape, bit no_gap);
		logic [31:0] base_u, base_v, step_u, step_v;
		bit          repeat_first;
		vtx_t        c;
		int          i;
		base_u       = rand_coord(4 << 16);
		base_v       = rand_coord(4 << 16);
		step_u       = rand_coord(ONE);
		step_v       = rand_coord(ONE);
		repeat_first = $urandom_range(0, 1);
		if (shape == SHAPE_STEEP) begin
			base_u = rand_coord(0);
			base_v = rand_coord(0);
		end
		for (i = 0; i < 3; i++) begin
			case (shape)
				SHAPE_PLAIN: begin
					c = corner(rand_coord(NEAR), rand_coord(NEAR), rand_coord(NEAR),
						rand_coord(4 << 16), rand_coord(4 << 16));
				end
				SHAPE_WIDE: begin
					c = corner(rand_coord(0), rand_coord(0), rand_coord(0),
						rand_coord(0), rand_coord(0));
				end
				SHAPE_FLAT: begin
					// uv corners on one line, or the second equal to the first
					c = corner(rand_coord(NEAR), rand_coord(NEAR), rand_coord(NEAR),
						base_u + ((repeat_first && i == 1) ? 32'd0 : 32'(i) * step_u),
						base_v + ((repeat_first && i == 1) ? 32'd0 : 32'(i) * step_v));
				end
				SHAPE_STEEP: begin
					// tiny uv spread against wide positions drives the quotient to its limits
					c = corner(rand_coord(0), rand_coord(0), rand_coord(0),
						base_u + rand_coord(3), base_v + rand_coord(3));
				end
				default: begin
					c = corner(
						rand_coord($urandom_range(0, 1) ? 0 : 1 << 20),
						rand_coord($urandom_range(0, 1) ? 0 : 1 << 20),
						rand_coord($urandom_range(0, 1) ? 0 : 1 << 20),
						rand_coord($urandom_range(0, 1) ? 0 : 1 << 20),
						rand_coord($urandom_range(0, 1) ? 0 : 1 << 20));
				end
			endcase
			offer_vertex(c, no_gap);
		end
	endtask

	initial begin : result_taker
		int  n;
		int  held_cycles;
		bit  long_hold_done;
		@(posedge arst_n);
		forever begin
			if (!long_hold_done && vertices_sent >= 120) begin
				// long hold-off so the block backs up into the vertex channel
				long_hold_done = 1'b1;
				res_stall <= 1'b1;
				for (held_cycles = 0; held_cycles < 1500; held_cycles++)
					@(posedge clk);
			end else begin
				n = idle_length();
				if (n > 0) begin
					res_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			res_stall <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	initial begin : vertex_source
		int     t;
		int     pick;
		shape_e shape;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unit basis
		send_triangle(corner(0, 0, 0, 0, 0), corner(ONE, 0, 0, ONE, 0),
			corner(0, ONE, 0, 0, ONE));
		// mirrored uv, negative determinant
		send_triangle(corner(0, 0, 0, 0, 0), corner(ONE, 0, 0, 0, ONE),
			corner(0, ONE, 0, ONE, 0));
		// all uv equal
		send_triangle(corner(0, ONE, 0, ONE, ONE), corner(ONE, 0, 0, ONE, ONE),
			corner(0, 0, ONE, ONE, ONE));
		// collinear uv
		send_triangle(corner(0, 0, 0, 0, 0), corner(ONE, 0, 0, ONE, ONE),
			corner(0, ONE, 0, 2 * ONE, 2 * ONE));
		// positive clamp
		send_triangle(corner(BOT, BOT, BOT, 0, 0), corner(TOP, TOP, TOP, 1, 0),
			corner(TOP, TOP, TOP, 0, 1));
		// negative clamp
		send_triangle(corner(TOP, TOP, TOP, 0, 0), corner(BOT, BOT, BOT, 1, 0),
			corner(BOT, BOT, BOT, 0, 1));
		// field extremes
		send_triangle(corner(TOP, BOT, 0, BOT, BOT), corner(BOT, TOP, TOP, TOP, BOT),
			corner(0, BOT, BOT, BOT, TOP));
		// all zero
		send_triangle(corner(0, 0, 0, 0, 0), corner(0, 0, 0, 0, 0), corner(0, 0, 0, 0, 0));

		for (t = 0; t < 100; t++) begin
			if (t == 75)
				drain_results();
			pick = $urandom_range(0, 9);
			case (pick)
				0, 1, 2, 3: shape = SHAPE_PLAIN;
				4:          shape = SHAPE_WIDE;
				5, 6:       shape = SHAPE_FLAT;
				7:          shape = SHAPE_STEEP;
				default:    shape = SHAPE_LOOSE;
			endcase
			random_triangle(shape, $urandom_range(0, 3) == 0);
		end

		drain_results();
		repeat (300) @(posedge clk);
		if (mismatches == 0 && results_owed == 0)
			$display("** triangle_tangent_basis: PASSED **");
		else
			$display("** triangle_tangent_basis: FAILED **");
		$finish;
	end

endmodule

// ----- triangle_tangent_basis.f -----
+incdir+rtl/core
rtl/core/ttb_pkg.sv
rtl/core/ttb_div.sv
rtl/core/triangle_tangent_basis.sv
sim/triangle_tangent_basis_checker.sv
sim/triangle_tangent_basis_test.sv
